FILE: sv/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types, constants and the UTF-8 encode function shared by the transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

  localparam int MaxBytes = 6;
  localparam int SeqBytes = 4;

  localparam logic [15:0] HighFirst = 16'hd800;
  localparam logic [15:0] HighLast  = 16'hdbff;
  localparam logic [15:0] LowFirst  = 16'hdc00;
  localparam logic [15:0] LowLast   = 16'hdfff;
  localparam logic [20:0] SuppBase  = 21'h10000;

  localparam logic MODE_UTF16  = 1'b0;
  localparam logic MODE_LATIN1 = 1'b1;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } unit_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } byte_item_t;

  // one UTF-8 sequence, bytes in send order from index 0
  typedef struct packed {
    logic [SeqBytes-1:0][7:0] seq_bytes;
    logic [2:0]               len;
  } enc_t;

  // everything one transaction produces
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] seq_bytes;
    logic [2:0]               count;
  } frame_t;

  function automatic enc_t utf8_encode(logic [20:0] cp);
    enc_t e;
    e.seq_bytes = '0;
    if (cp[20:7] == '0) begin
      e.seq_bytes[0] = {1'b0, cp[6:0]};
      e.len = 3'd1;
    end else if (cp[20:11] == '0) begin
      e.seq_bytes[0] = {3'b110, cp[10:6]};
      e.seq_bytes[1] = {2'b10, cp[5:0]};
      e.len = 3'd2;
    end else if (cp[20:16] == '0) begin
      e.seq_bytes[0] = {4'b1110, cp[15:12]};
      e.seq_bytes[1] = {2'b10, cp[11:6]};
      e.seq_bytes[2] = {2'b10, cp[5:0]};
      e.len = 3'd3;
    end else begin
      e.seq_bytes[0] = {5'b11110, cp[20:18]};
      e.seq_bytes[1] = {2'b10, cp[17:12]};
      e.seq_bytes[2] = {2'b10, cp[11:6]};
      e.seq_bytes[3] = {2'b10, cp[5:0]};
      e.len = 3'd4;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: sv/utf16_to_utf8_transcoder_top.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_top
// UTF-16 / Latin-1 code units in, UTF-8 bytes out, last byte of each
// transaction's output marked by run_last.
// ----------------------------------------------------------------------------
// Each accepted code unit is encoded in the cycle it is taken and its bytes
// (zero to six) are loaded into a result register, which sends one byte per
// cycle while byte_stall is low. A high surrogate that is being held yields
// nothing. The byte output of the result register sets the rate; the next
// unit is taken in the same cycle the last byte of the previous one leaves.
// source_mode (0 = UTF-16, 1 = Latin-1 in bits 7..0) is written with
// cfg_wr_en and must change only while idle.
`default_nettype none

module utf16_to_utf8_transcoder_top
  import u16u8_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       unit_valid,
  output logic            unit_stall,
  input  wire unit_item_t unit_data,
  output logic            byte_valid,
  input  wire logic       byte_stall,
  output byte_item_t      byte_data
);

  logic   source_mode;
  logic   accept;
  logic   busy;
  logic   draining;
  logic   load;
  frame_t frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_mode <= MODE_UTF16;
    end else if (cfg_wr_en) begin
      source_mode <= cfg_wr_data;
    end
  end

  assign unit_stall = busy && !draining;
  assign accept     = unit_valid && !unit_stall;
  assign load       = accept && (frame.count != 3'd0);

  u16u8_encoder u_encoder (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .source_mode (source_mode),
    .item        (unit_data),
    .frame       (frame)
  );

  u16u8_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .load_frame (frame),
    .busy       (busy),
    .draining   (draining),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data)
  );

endmodule

`default_nettype wire

FILE: sv/u16u8_encoder.sv
// ----------------------------------------------------------------------------
// u16u8_encoder
// Surrogate holding state and the single-pass encode of one code unit into
// up to two UTF-8 sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_encoder
  import u16u8_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic       source_mode,
  input  wire unit_item_t item,
  output frame_t          frame
);

  logic       held_valid;
  logic [9:0] held_high_bits;
  logic       held_valid_next;
  logic [9:0] held_high_bits_next;

  logic       is_low;
  logic       is_high;
  logic       use_a;
  logic       use_b;
  logic [20:0] cp_a;
  logic [20:0] cp_b;
  enc_t       enc_a;
  enc_t       enc_b;
  logic [2:0] len_a;
  logic [2:0] len_b;

  assign is_low  = (item.code_unit >= LowFirst) && (item.code_unit <= LowLast);
  assign is_high = (item.code_unit >= HighFirst) && (item.code_unit <= HighLast);

  always_comb begin
    held_valid_next     = held_valid;
    held_high_bits_next = held_high_bits;
    use_a = 1'b0;
    use_b = 1'b0;
    cp_a  = {5'b0, 6'b110110, held_high_bits};
    cp_b  = {5'b0, item.code_unit};
    if (source_mode == MODE_LATIN1) begin
      use_a           = held_valid;
      use_b           = 1'b1;
      cp_b            = {13'b0, item.code_unit[7:0]};
      held_valid_next = 1'b0;
    end else if (held_valid && is_low) begin
      // complete surrogate pair
      use_a           = 1'b1;
      cp_a            = SuppBase + {1'b0, held_high_bits, item.code_unit[9:0]};
      held_valid_next = 1'b0;
    end else begin
      // flush a held surrogate that found no partner, then the unit alone or hold a new high
      use_a = held_valid;
      if (is_high && !item.last_unit) begin
        held_valid_next     = 1'b1;
        held_high_bits_next = item.code_unit[9:0];
      end else begin
        use_b           = 1'b1;
        held_valid_next = 1'b0;
      end
    end
  end

  assign enc_a = utf8_encode(cp_a);
  assign enc_b = utf8_encode(cp_b);
  assign len_a = use_a ? enc_a.len : 3'd0;
  assign len_b = use_b ? enc_b.len : 3'd0;

  always_comb begin
    logic [2:0] k;
    frame.count     = len_a + len_b;
    frame.seq_bytes = '0;
    for (int i = 0; i < MaxBytes; i++) begin
      k = 3'(i) - len_a;
      if (3'(i) < len_a) begin
        frame.seq_bytes[i] = enc_a.seq_bytes[i[1:0]];
      end else if (k < len_b) begin
        frame.seq_bytes[i] = enc_b.seq_bytes[k[1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid     <= 1'b0;
      held_high_bits <= '0;
    end else if (accept) begin
      held_valid     <= held_valid_next;
      held_high_bits <= held_high_bits_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/u16u8_serializer.sv
// ----------------------------------------------------------------------------
// u16u8_serializer
// Result register for one transaction's bytes, sent out one per cycle unless byte_stall holds them.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_serializer
  import u16u8_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   load,
  input  wire frame_t load_frame,
  output logic        busy,
  output logic        draining,
  output logic        byte_valid,
  input  wire logic   byte_stall,
  output byte_item_t  byte_data
);

  frame_t     frame;
  logic       frame_valid;
  logic [2:0] idx;
  logic       at_last;
  logic       pop;

  assign at_last  = (idx == frame.count - 3'd1);
  assign pop      = frame_valid && !byte_stall;

  assign busy       = frame_valid;
  assign draining   = pop && at_last;
  assign byte_valid = frame_valid;
  assign byte_data.out_byte = frame.seq_bytes[idx];
  assign byte_data.run_last = at_last;

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= load_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      idx         <= '0;
    end else if (load) begin
      frame_valid <= 1'b1;
      idx         <= '0;
    end else if (pop) begin
      if (at_last) begin
        frame_valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_utf16_to_utf8_transcoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_transcoder_top
// Self-checking bench for the UTF-16 / Latin-1 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
// A queue of code units feeds a clocked driver. Each accepted unit runs through
// a local encoder that tracks the held high surrogate and the source mode, and
// the bytes it yields are queued. A clocked monitor pops one expected byte per
// accepted output transaction and compares both fields. Directed units cover
// the encoding boundaries and the surrogate corner cases. Random phases follow
// in both modes with random idling on either side, bursts with no idling, and
// one long output hold that backs the block up.
// ----------------------------------------------------------------------------
module tb_utf16_to_utf8_transcoder_top;
  import u16u8_pkg::*;

  localparam int unsigned LongHold  = 64;
  localparam int unsigned DrainWait = 8;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       unit_valid = 1'b0;
  logic       unit_stall;
  unit_item_t unit_data = '0;
  logic       byte_valid;
  logic       byte_stall = 1'b0;
  byte_item_t byte_data;

  utf16_to_utf8_transcoder_top uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_data  (unit_data),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // encoder state
  logic       src_mode = MODE_UTF16;
  logic       held_valid = 1'b0;
  logic [9:0] held_bits = '0;

  unit_item_t  pending_units[$];
  byte_item_t  run_bytes[$];
  byte_item_t  utf8_expect[$];
  int unsigned mismatches = 0;

  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          hold_armed = 1'b0;
  bit          hold_used;
  int unsigned hold_left;
  int unsigned tx_gap;
  int unsigned rx_wait;

  function automatic void add_byte(logic [7:0] v);
    byte_item_t b;
    b.out_byte = v;
    b.run_last = 1'b0;
    run_bytes.push_back(b);
  endfunction

  function automatic void add_code_point(logic [20:0] cp);
    if (cp < 21'h80) begin
      add_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void predict_unit(unit_item_t u);
    logic [15:0] cu;
    logic        is_low;
    logic        is_high;
    logic        paired;
    byte_item_t  b;
    cu = u.code_unit;
    paired = 1'b0;
    run_bytes.delete();
    if (src_mode == MODE_LATIN1) begin
      if (held_valid) begin
        add_code_point({5'd0, HighFirst | {6'd0, held_bits}});
        held_valid = 1'b0;
      end
      add_code_point({13'd0, cu[7:0]});
    end else begin
      is_low  = (cu >= LowFirst) && (cu <= LowLast);
      is_high = (cu >= HighFirst) && (cu <= HighLast);
      if (held_valid) begin
        held_valid = 1'b0;
        if (is_low) begin
          add_code_point(SuppBase + {1'b0, held_bits, cu[9:0]});
          paired = 1'b1;
        end else begin
          add_code_point({5'd0, HighFirst | {6'd0, held_bits}});
        end
      end
      if (!paired) begin
        if (is_high && !u.last_unit) begin
          held_valid = 1'b1;
          held_bits  = cu[9:0];
        end else begin
          add_code_point({5'd0, cu});
        end
      end
    end
    if (run_bytes.size() != 0) begin
      b = run_bytes.pop_back();
      b.run_last = 1'b1;
      run_bytes.push_back(b);
    end
    foreach (run_bytes[i]) utf8_expect.push_back(run_bytes[i]);
  endfunction

  function automatic void check_byte(byte_item_t got);
    byte_item_t want;
    if (utf8_expect.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected byte: out_byte=%02h run_last=%0b", got.out_byte, got.run_last);
    end else begin
      want = utf8_expect.pop_front();
      if (got.out_byte !== want.out_byte || got.run_last !== want.run_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("byte mismatch: expected out_byte=%02h run_last=%0b, got out_byte=%02h run_last=%0b",
                   want.out_byte, want.run_last, got.out_byte, got.run_last);
      end
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      unit_valid <= 1'b0;
      tx_gap     <= 0;
    end else begin
      if (unit_valid && !unit_stall) predict_unit(unit_data);
      if (!unit_valid || !unit_stall) begin
        if (tx_gap != 0) begin
          unit_valid <= 1'b0;
          tx_gap     <= tx_gap - 1;
        end else if (pending_units.size() != 0) begin
          unit_valid <= 1'b1;
          unit_data  <= pending_units.pop_front();
          tx_gap     <= tx_quiet ? 0 : $urandom_range(0, 3);
        end else begin
          unit_valid <= 1'b0;
        end
      end
    end
  end

  // one long output hold, armed by the stimulus
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_armed && !hold_used) begin
      hold_left <= LongHold;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin : rx_side
    int unsigned nxt;
    if (rst) begin
      byte_stall <= 1'b0;
      rx_wait    <= 0;
    end else begin
      if (byte_valid && !byte_stall) begin
        check_byte(byte_data);
        nxt = rx_quiet ? 0 : $urandom_range(0, 3);
      end else begin
        nxt = (rx_wait != 0) ? rx_wait - 1 : 0;
      end
      rx_wait    <= nxt;
      byte_stall <= (nxt != 0) || (hold_left > 1);
    end
  end

  task automatic set_mode(logic m);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    src_mode = m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic add_unit(logic [15:0] cu, logic lst);
    unit_item_t u;
    u.code_unit = cu;
    u.last_unit = lst;
    pending_units.push_back(u);
  endtask

  task automatic queue_random_units(int unsigned count);
    unit_item_t  u;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      u.last_unit = ($urandom_range(0, 7) == 0);
      if (src_mode == MODE_LATIN1 || (pick >= 45 && pick < 65)) begin
        u.code_unit = 16'($urandom_range(0, 16'hffff));
      end else if (pick < 25) begin
        u.code_unit = 16'($urandom_range(0, 16'h7f));
      end else if (pick < 45) begin
        u.code_unit = 16'($urandom_range(16'h80, 16'h7ff));
      end else if (pick < 85) begin
        // well-formed pair
        u.code_unit = 16'($urandom_range(HighFirst, HighLast));
        u.last_unit = 1'b0;
        pending_units.push_back(u);
        u.code_unit = 16'($urandom_range(LowFirst, LowLast));
        u.last_unit = ($urandom_range(0, 7) == 0);
      end else if (pick < 93) begin
        u.code_unit = 16'($urandom_range(HighFirst, HighLast));
      end else begin
        u.code_unit = 16'($urandom_range(LowFirst, LowLast));
      end
      pending_units.push_back(u);
    end
  endtask

  // wait until every queued transaction has gone through, then let the
  // block settle (a held surrogate produces nothing to wait on)
  task automatic wait_drained();
    @(negedge clk);
    while (pending_units.size() != 0 || unit_valid || utf8_expect.size() != 0)
      @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    set_mode(MODE_UTF16);
    add_unit(16'h0000, 1'b0);
    add_unit(16'h007f, 1'b0);
    add_unit(16'h0080, 1'b0);
    add_unit(16'h07ff, 1'b0);
    add_unit(16'h0800, 1'b0);
    add_unit(16'hffff, 1'b1);
    add_unit(HighFirst, 1'b0);
    add_unit(LowFirst, 1'b0);
    add_unit(HighLast, 1'b0);
    add_unit(LowLast, 1'b1);
    add_unit(LowFirst, 1'b0);      // lone low
    add_unit(16'hd801, 1'b0);      // held, then plain unit
    add_unit(16'h0041, 1'b0);
    add_unit(16'hd802, 1'b0);      // held, then another high that gets held
    add_unit(16'hdbfe, 1'b0);
    add_unit(16'hdfff, 1'b0);
    add_unit(16'hd803, 1'b0);      // held, then high on last unit: six bytes
    add_unit(16'hdaaa, 1'b1);
    add_unit(HighLast, 1'b1);      // high on last unit is never held
    add_unit(16'hd9ab, 1'b0);      // stays held across the mode change
    wait_drained();

    set_mode(MODE_LATIN1);
    add_unit(16'hffff, 1'b0);      // held surrogate first, then 0xff
    add_unit(16'h0000, 1'b0);
    add_unit(16'h007f, 1'b0);
    add_unit(16'h0080, 1'b0);
    add_unit(16'hd8ff, 1'b0);
    add_unit(16'h1234, 1'b1);
    wait_drained();

    set_mode(MODE_UTF16);
    queue_random_units(120);
    wait_drained();

    set_mode(MODE_LATIN1);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    queue_random_units(60);
    wait_drained();

    // back-pressure: sender keeps offering while the output is held off
    set_mode(MODE_UTF16);
    rx_quiet = 1'b0;
    queue_random_units(120);
    hold_armed = 1'b1;
    wait_drained();

    set_mode(MODE_LATIN1);
    tx_quiet = 1'b0;
    queue_random_units(50);
    wait_drained();

    set_mode(MODE_UTF16);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    queue_random_units(50);
    wait_drained();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
